FILE: rtl/lfo_pkg.sv
// ----------------------------------------------------------------------------
// lfo_pkg
// shared types, constants and the quarter-wave sine table of the lfo block
// ----------------------------------------------------------------------------
package lfo_pkg;

  // phase width and sine table size
  localparam int PHASE_BITS    = 24;
  localparam int SINE_DEPTH    = 256;
  localparam int SINE_IDX_W    = $clog2(SINE_DEPTH);
  localparam int SINE_ADDR_W   = $clog2(SINE_DEPTH + 1);

  // field widths
  localparam int SONG_POS_W    = 48;
  localparam int SYNC_FRAC_W   = 28;
  localparam int SAMPLE_W      = 17;
  localparam int WAVE_W        = 17;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int INC_W         = 24;
  localparam int AMP_W         = 16;
  localparam int OFFSET_W      = 16;
  localparam int ALPHA_W       = 17;
  localparam int RATE_SEL_W    = 4;
  localparam int RATE_MUL_W    = 8;
  localparam int RAND_W        = 16;
  localparam int LFSR_W        = 32;

  // datapath product and difference widths
  localparam int PROD1_W       = WAVE_W + AMP_W + 1;
  localparam int DIFF_W        = 20;
  localparam int PROD2_W       = DIFF_W + ALPHA_W + 1;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // pi/2 in q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sync rate multipliers, scaled by 16
  localparam int RATE_COUNT = 10;
  localparam logic [RATE_SEL_W-1:0] RATE_LAST = RATE_SEL_W'(RATE_COUNT - 1);
  typedef logic [RATE_MUL_W-1:0] rate_rom_t [0:RATE_COUNT-1];
  localparam rate_rom_t RATE_X16 = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16,
                                     8'd32, 8'd48, 8'd64, 8'd96, 8'd128};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC  = 3'd0,
    CFG_WAVE_SEL   = 3'd1,
    CFG_SYNC_EN    = 3'd2,
    CFG_SYNC_RATE  = 3'd3,
    CFG_RETRIG_EN  = 3'd4,
    CFG_AMPLITUDE  = 3'd5,
    CFG_OFFSET     = 3'd6,
    CFG_ALPHA      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_RANDOM   = 3'd4
  } wave_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_CHECK,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_WAVE,
    ST_SCALE,
    ST_TARGET,
    ST_SMOOTH,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic phase_en;
    logic commit;
    logic draw_a;
    logic draw_b;
    logic wave_en;
    logic scale_en;
    logic target_en;
    logic smooth_en;
    logic finish;
  } lfo_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_need;
    logic out_busy;
  } lfo_status_t;

  typedef logic [15:0] sine_rom_t [0:SINE_DEPTH];

  // quarter-wave table from a fixed-point taylor series, built at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] r;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      t = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
      t2 = (t * t) >> 30;
      term = t;
      plus = t;
      minus = '0;
      for (int k = 1; k <= 5; k++) begin
        term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      r = (plus - minus + 64'd16384) >> 15;
      rom[i] = (r > 64'd32768) ? 16'h8000 : r[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/lfo_ctrl.sv
// ----------------------------------------------------------------------------
// lfo_ctrl
// sequencer that walks one sample through the lfo datapath
// ----------------------------------------------------------------------------
module lfo_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfo_pkg::lfo_status_t status,
  output lfo_pkg::lfo_cmd_t    cmd
);
  import lfo_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PHASE;
      ST_PHASE:  state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = status.draw_need ? ST_DRAW_A : ST_WAVE;
      ST_DRAW_A: state_nxt = ST_DRAW_B;
      ST_DRAW_B: state_nxt = ST_WAVE;
      ST_WAVE:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_TARGET;
      ST_TARGET: state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_FINISH;
      ST_FINISH: if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PHASE:  cmd.phase_en = 1'b1;
      ST_CHECK:  cmd.commit = !status.draw_need;
      ST_DRAW_A: cmd.draw_a = 1'b1;
      ST_DRAW_B: begin
        cmd.draw_b = 1'b1;
        cmd.commit = 1'b1;
      end
      ST_WAVE:   cmd.wave_en = 1'b1;
      ST_SCALE:  cmd.scale_en = 1'b1;
      ST_TARGET: cmd.target_en = 1'b1;
      ST_SMOOTH: cmd.smooth_en = 1'b1;
      ST_FINISH: cmd.finish = !status.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: rtl/lfo_datapath.sv
// ----------------------------------------------------------------------------
// lfo_datapath
// config registers, phase, waveform, scaling, smoothing and output register
// ----------------------------------------------------------------------------
module lfo_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_note_on,
  input  logic signed [lfo_pkg::SONG_POS_W-1:0]   in_song_position,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lfo_pkg::SAMPLE_W-1:0]     out_sample_value,
  input  lfo_pkg::lfo_cmd_t                       cmd,
  output lfo_pkg::lfo_status_t                    status
);
  import lfo_pkg::*;

  // config
  logic [INC_W-1:0]           phase_inc_r;
  logic [2:0]                 wave_sel_r;
  logic                       sync_en_r;
  logic [RATE_SEL_W-1:0]      sync_rate_r;
  logic                       retrig_en_r;
  logic [AMP_W-1:0]           amp_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [ALPHA_W-1:0]         alpha_r;

  // state
  logic [PHASE_BITS-1:0]      accum_r;
  logic [PHASE_BITS-1:0]      prev_phase_r;
  logic [PHASE_BITS-1:0]      phase_r;
  logic                       pending_r;
  logic [LFSR_W-1:0]          lfsr_r;
  logic signed [RAND_W-1:0]   held_r;
  logic signed [SAMPLE_W-1:0] prev_out_r;
  logic [SYNC_FRAC_W-1:0]     song_frac_r;

  // pipeline
  logic signed [WAVE_W-1:0]   wave_r;
  logic signed [PROD1_W-1:0]  prod1_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [PROD2_W-1:0]  prod2_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_r;

  logic [RATE_SEL_W-1:0]      rate_idx;
  logic [SYNC_FRAC_W+RATE_MUL_W-1:0] sync_prod;
  logic [31:0]                sync_frac32;
  logic [PHASE_BITS-1:0]      sync_phase;
  logic [LFSR_W-1:0]          lfsr_nxt;
  logic [31:0]                p32;
  logic [SINE_IDX_W-1:0]      sine_idx;
  logic [SINE_ADDR_W-1:0]     sine_addr;
  logic signed [WAVE_W-1:0]   sine_mag;
  logic signed [WAVE_W:0]     tri_val;
  logic signed [WAVE_W-1:0]   wave_nxt;
  logic signed [PROD1_W-1:0]  target_full;
  logic signed [PROD2_W-1:0]  sum_full;
  logic signed [SAMPLE_W-1:0] out_nxt;
  logic                       is_random;

  // galois lfsr, eight steps
  function automatic logic [LFSR_W-1:0] lfsr_step8(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = (v >> 1) ^ ({LFSR_W{v[0]}} & LFSR_TAPS);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= INC_W'(35);
      wave_sel_r  <= WAVE_SINE;
      sync_en_r   <= 1'b0;
      sync_rate_r <= '0;
      retrig_en_r <= 1'b0;
      amp_r       <= AMP_W'(32768);
      offset_r    <= '0;
      alpha_r     <= ALPHA_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PHASE_INC: phase_inc_r <= cfg_data[INC_W-1:0];
        CFG_WAVE_SEL:  wave_sel_r  <= cfg_data[2:0];
        CFG_SYNC_EN:   sync_en_r   <= cfg_data[0];
        CFG_SYNC_RATE: sync_rate_r <= cfg_data[RATE_SEL_W-1:0];
        CFG_RETRIG_EN: retrig_en_r <= cfg_data[0];
        CFG_AMPLITUDE: amp_r       <= cfg_data[AMP_W-1:0];
        CFG_OFFSET:    offset_r    <= cfg_data[OFFSET_W-1:0];
        CFG_ALPHA:     alpha_r     <= cfg_data[ALPHA_W-1:0];
        default:       ;
      endcase
    end
  end

  // sync phase: fraction of song position times rate
  assign rate_idx    = (sync_rate_r > RATE_LAST) ? RATE_LAST : sync_rate_r;
  assign sync_prod   = song_frac_r * RATE_X16[rate_idx];
  assign sync_frac32 = {sync_prod[SYNC_FRAC_W-1:0], 4'b0000};
  assign sync_phase  = sync_frac32[31 -: PHASE_BITS];

  assign lfsr_nxt  = lfsr_step8(lfsr_r);
  assign is_random = (wave_sel_r == WAVE_RANDOM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      prev_phase_r <= '0;
      pending_r    <= 1'b1;
      lfsr_r       <= LFSR_SEED;
      held_r       <= '0;
      prev_out_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load && in_note_on && retrig_en_r) begin
        accum_r   <= '0;
        pending_r <= 1'b1;
      end else if (cmd.phase_en && !sync_en_r) begin
        accum_r <= accum_r + PHASE_BITS'(phase_inc_r);
      end
      if (cmd.draw_a || cmd.draw_b) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cmd.draw_b) begin
        held_r <= lfsr_nxt[RAND_W-1:0];
      end
      if (cmd.commit && is_random) begin
        prev_phase_r <= phase_r;
        pending_r    <= 1'b0;
      end
      if (cmd.finish) begin
        prev_out_r  <= out_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // waveform
  assign p32       = 32'(phase_r) << (32 - PHASE_BITS);
  assign sine_idx  = p32[29 -: SINE_IDX_W];
  assign sine_addr = p32[30] ? SINE_ADDR_W'(SINE_DEPTH - int'(sine_idx))
                             : SINE_ADDR_W'(sine_idx);
  assign sine_mag  = $signed({1'b0, SINE_ROM[sine_addr]});
  assign tri_val   = p32[31] ? (18'sd98304 - $signed({1'b0, p32[31:15]}))
                             : ($signed({1'b0, p32[31:15]}) - 18'sd32768);

  always_comb begin
    case (wave_sel_t'(wave_sel_r))
      WAVE_SINE:     wave_nxt = p32[31] ? -sine_mag : sine_mag;
      WAVE_TRIANGLE: wave_nxt = tri_val[WAVE_W-1:0];
      WAVE_SQUARE:   wave_nxt = p32[31] ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:      wave_nxt = $signed({1'b0, p32[31:16]}) - 17'sd32768;
      WAVE_RANDOM:   wave_nxt = WAVE_W'(held_r);
      default:       wave_nxt = '0;
    endcase
  end

  // scale, offset, one-pole smoothing
  assign target_full = (prod1_r >>> 15) + PROD1_W'(offset_r) - PROD1_W'(prev_out_r);
  assign sum_full    = (prod2_r >>> 16) + PROD2_W'(prev_out_r);

  always_comb begin
    if (sum_full > PROD2_W'(65535)) begin
      out_nxt = 17'sd65535;
    end else if (sum_full < -PROD2_W'(65536)) begin
      out_nxt = -17'sd65536;
    end else begin
      out_nxt = sum_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      song_frac_r <= in_song_position[SYNC_FRAC_W-1:0];
    end
    if (cmd.phase_en) begin
      phase_r <= sync_en_r ? sync_phase : accum_r;
    end
    if (cmd.wave_en) begin
      wave_r <= wave_nxt;
    end
    if (cmd.scale_en) begin
      prod1_r <= PROD1_W'(wave_r * $signed({1'b0, amp_r}));
    end
    if (cmd.target_en) begin
      diff_r <= target_full[DIFF_W-1:0];
    end
    if (cmd.smooth_en) begin
      prod2_r <= PROD2_W'(diff_r * $signed({1'b0, alpha_r}));
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign status.draw_need = is_random && (pending_r || (phase_r < prev_phase_r));
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_r;

endmodule

FILE: rtl/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// low-frequency oscillator with five waveforms and one-pole output smoothing
// ----------------------------------------------------------------------------
// each input word is one sample tick and yields one output word. the phase
// comes from a 24-bit accumulator stepped by phase_increment, or in sync mode
// from the fraction of the song position times a beat multiplier. waveforms:
// sine (quarter-wave table), triangle, square, saw, sample-and-hold noise
// drawn from a 32-bit galois lfsr. the wave is scaled by amplitude, offset is
// added, a one-pole smoother follows and the result saturates to q2.15.
// a note-on with retrigger enabled clears the phase and forces a new draw.
// timing: one sample at a time through a sequencer: phase, check, the draw_a
// and draw_b states when the noise waveform draws (the lfsr advances 8 steps
// in each), wave, scale, target, smooth and finish, where the result lands in
// the output register. the next word is taken in the cycle after the result
// is registered; a result waiting on out_ready does not stop the next
// sample, only its final write-back.
// configuration writes are taken in any cycle but must only come while idle.
// ----------------------------------------------------------------------------
module lfo_waveform_generator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // sample tick words
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_note_on,
  input  logic signed [lfo_pkg::SONG_POS_W-1:0]   in_song_position,
  // output samples
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lfo_pkg::SAMPLE_W-1:0]     out_sample_value,
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import lfo_pkg::*;

  lfo_cmd_t    cmd;
  lfo_status_t status;

  // register port never stalls
  assign cfg_ready = 1'b1;

  // sequencer
  lfo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // phase, wave, scale, smoothing and output register
  lfo_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_note_on       (in_note_on),
    .in_song_position (in_song_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

FILE: rtl/lfo_checker.sv
// ----------------------------------------------------------------------------
// lfo_checker
// port-level checks of the lfo block, bound to the top level
// ----------------------------------------------------------------------------
module lfo_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [lfo_pkg::SAMPLE_W-1:0]   out_sample_value
);
  import lfo_pkg::*;

  logic [2:0] pend_r;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("output word with no input word behind it");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more than two samples outstanding");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sample_value (out_sample_value)
);

FILE: sim/tb_lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// tb_lfo_waveform_generator
// self-checking bench for the lfo waveform generator
// ----------------------------------------------------------------------------
// sample ticks go in through a valid/ready channel and each accepted tick is
// run through a bit-exact predictor of the oscillator (phase accumulator or
// song-position sync, five waveforms, gain, level, one-pole smoother,
// saturation). the expected samples queue up and every output word is checked
// against the oldest one. register writes happen only with the block idle.
// a directed part hits the corners, then random phases reshuffle all
// registers and send random ticks, with random idling on both channels in all but calm phases.
// ----------------------------------------------------------------------------
module tb_lfo_waveform_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import lfo_pkg::*;

  // predictor constants
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int          SINE_STEPS       = 256;
  localparam logic [31:0] NOISE_SEED       = 32'h0000_ACE1;
  localparam logic [31:0] NOISE_TAPS       = 32'h8020_0003;
  localparam logic [3:0]  RATE_TOP         = 4'd9;
  localparam longint      SAMPLE_MAX       = 65535;
  localparam longint      SAMPLE_MIN       = -65536;

  // song position corners, q20.28
  localparam logic [47:0] SPOS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SPOS_MIN  = 48'h8000_0000_0000;
  localparam logic [47:0] SPOS_NEG1 = 48'hFFFF_FFFF_FFFF;

  // run shape
  localparam int RANDOM_PHASES   = 12;
  localparam int TICKS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT  = 3000;

  // --------------------------------------------------------------------------
  // predictor and expected sample store
  // --------------------------------------------------------------------------
  class lfo_sample_board;
    // register copies
    logic [23:0]        step_size;
    logic [2:0]         shape;
    logic               locked;
    logic [3:0]         beat_rate;
    logic               retrig;
    logic [15:0]        gain;
    logic signed [15:0] level;
    logic [16:0]        alpha;

    // oscillator state
    logic [23:0] accum;
    logic [23:0] last_phase;
    longint      prev_out;
    longint      held;
    bit          pending;
    logic [31:0] noise;

    int          sine_q [0:SINE_STEPS];
    int unsigned beat_x16 [10];

    logic signed [16:0] expected_samples [$];
    int                 errors;

    function new();
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] r;
      // quarter sine, odd taylor series to x^11, rounded to q1.15
      for (int i = 0; i <= SINE_STEPS; i++) begin
        t = (64'(i) * QUARTER_TURN_Q30) / SINE_STEPS;
        t2 = (t * t) >> 30;
        term = t;
        plus = t;
        minus = '0;
        for (int k = 1; k <= 5; k++) begin
          term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            minus = minus + term;
          end else begin
            plus = plus + term;
          end
        end
        r = (plus - minus + 64'd16384) >> 15;
        sine_q[i] = (r > 64'd32768) ? 32768 : int'(r);
      end
      beat_x16 = '{1, 2, 4, 8, 16, 32, 48, 64, 96, 128};
      step_size  = 24'd35;
      shape      = WAVE_SINE;
      locked     = 1'b0;
      beat_rate  = '0;
      retrig     = 1'b0;
      gain       = 16'd32768;
      level      = '0;
      alpha      = 17'd65536;
      accum      = '0;
      last_phase = '0;
      prev_out   = 0;
      held       = 0;
      pending    = 1'b1;
      noise      = NOISE_SEED;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_reg_t idx, logic [23:0] d);
      case (idx)
        CFG_PHASE_INC: step_size = d;
        CFG_WAVE_SEL:  shape     = d[2:0];
        CFG_SYNC_EN:   locked    = d[0];
        CFG_SYNC_RATE: beat_rate = d[3:0];
        CFG_RETRIG_EN: retrig    = d[0];
        CFG_AMPLITUDE: gain      = d[15:0];
        CFG_OFFSET:    level     = d[15:0];
        CFG_ALPHA:     alpha     = d[16:0];
        default: ;
      endcase
    endfunction

    // 16 galois steps, low half becomes the new held level
    function void draw_noise();
      for (int i = 0; i < 16; i++) begin
        noise = (noise >> 1) ^ ({32{noise[0]}} & NOISE_TAPS);
      end
      held = longint'($signed(noise[15:0]));
    endfunction

    function longint shape_value(logic [23:0] ph);
      logic [31:0] p32;
      logic [7:0]  idx;
      longint      v;
      p32 = {ph, 8'h00};
      case (shape)
        WAVE_SINE: begin
          // table index is the top 8 bits within the quadrant
          idx = p32[29:22];
          v = p32[30] ? longint'(sine_q[SINE_STEPS - int'(idx)]) : longint'(sine_q[idx]);
          return p32[31] ? -v : v;
        end
        WAVE_TRIANGLE: begin
          if (!p32[31]) begin
            return longint'(p32 >> 15) - 32768;
          end
          return 98304 - longint'(p32 >> 15);
        end
        WAVE_SQUARE:   return p32[31] ? -32768 : 32768;
        WAVE_SAW:      return longint'(p32 >> 16) - 32768;
        WAVE_RANDOM: begin
          // new draw on a forced draw or when the phase wrapped
          if (pending || ph < last_phase) begin
            draw_noise();
          end
          last_phase = ph;
          pending = 1'b0;
          return held;
        end
        default:       return 0;
      endcase
    endfunction

    function void accept_tick(logic note, logic [47:0] pos);
      logic [23:0] ph;
      logic [63:0] prod;
      logic [3:0]  r;
      longint      tgt;
      longint      nxt;
      if (note && retrig) begin
        accum = '0;
        pending = 1'b1;
      end
      if (locked) begin
        r = (beat_rate > RATE_TOP) ? RATE_TOP : beat_rate;
        prod = 64'(pos) * 64'(beat_x16[r]);
        // 28-bit beat fraction, top 24 bits are the phase
        ph = prod[27:4];
      end else begin
        ph = accum;
      end
      tgt = ((shape_value(ph) * longint'(gain)) >>> 15) + longint'(level);
      nxt = prev_out + (((tgt - prev_out) * longint'(alpha)) >>> 16);
      if (nxt > SAMPLE_MAX) nxt = SAMPLE_MAX;
      if (nxt < SAMPLE_MIN) nxt = SAMPLE_MIN;
      prev_out = nxt;
      expected_samples.push_back(nxt[16:0]);
      if (!locked) begin
        accum = accum + step_size;
      end
    endfunction

    task check_sample(logic signed [16:0] got);
      logic signed [16:0] want;
      if (expected_samples.size() == 0) begin
        report($sformatf("sample_value %0d with no sample expected", got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        report($sformatf("sample_value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid         = 1'b0;
  logic                             in_ready;
  logic                             in_note_on       = 1'b0;
  logic signed [SONG_POS_W-1:0]     in_song_position = '0;
  logic                             out_valid;
  logic                             out_ready        = 1'b0;
  logic signed [SAMPLE_W-1:0]       out_sample_value;
  logic                             cfg_valid        = 1'b0;
  logic                             cfg_ready;
  logic [CFG_IDX_W-1:0]             cfg_index        = '0;
  logic [CFG_DATA_W-1:0]            cfg_data         = '0;

  always #4 clk = ~clk;

  lfo_waveform_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_note_on       (in_note_on),
    .in_song_position (in_song_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  lfo_sample_board board = new();

  // calm phases run without any idling on either side
  bit          calm        = 1'b0;
  logic [47:0] song_cursor = '0;
  int          ready_hold  = 0;
  int          quiet_cycles = 0;

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // four in ten ticks follow a running song position so sync phases move
  // forward and wrap the way a transport would, one in ten is a corner, the rest are arbitrary
  function automatic logic [47:0] next_position();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return SPOS_MAX;
          2: return SPOS_MIN;
          default: return SPOS_NEG1;
        endcase
      end
      1, 2, 3, 4: begin
        song_cursor = song_cursor + 48'($urandom_range(0, 32'h0010_0000));
        return song_cursor;
      end
      default: return 48'({$urandom, $urandom} >> 16);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // output side: check every taken word, stall ready at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      board.check_sample(out_sample_value);
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // watchdog: cycles in a row with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one register write, valid drops again once the write is taken
  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one sample tick after a random gap; with no gap valid just stays high
  task automatic feed_tick(logic note, logic [47:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_note_on       <= note;
    in_song_position <= pos;
    do @(posedge clk); while (!in_ready);
    board.accept_tick(note, pos);
  endtask

  // stop sending, wait for every expected sample, then for the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all registers get a fresh value, corners picked often
  task automatic shuffle_regs();
    logic [23:0] v;
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = 24'hFF_FFFF;
      2: v = 24'($urandom_range(1, 4095));
      default: v = 24'($urandom);
    endcase
    write_reg(CFG_PHASE_INC, v);
    v = ($urandom_range(0, 9) < 8) ? 24'($urandom_range(0, WAVE_RANDOM))
                                    : 24'($urandom_range(WAVE_RANDOM + 1, 7));
    write_reg(CFG_WAVE_SEL, v);
    write_reg(CFG_SYNC_EN, 24'($urandom_range(0, 1)));
    write_reg(CFG_SYNC_RATE, 24'($urandom_range(0, 15)));
    write_reg(CFG_RETRIG_EN, 24'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = 24'd32768;
      2: v = 24'h00_FFFF;
      default: v = 24'($urandom_range(0, 32768));
    endcase
    write_reg(CFG_AMPLITUDE, v);
    case ($urandom_range(0, 5))
      0: v = 24'h00_8000;
      1: v = 24'h00_7FFF;
      2: v = '0;
      default: v = 24'($urandom_range(0, 16'hFFFF));
    endcase
    write_reg(CFG_OFFSET, v);
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = 24'd65536;
      2: v = 24'h01_FFFF;
      default: v = 24'($urandom_range(0, 65536));
    endcase
    write_reg(CFG_ALPHA, v);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sine, free running, unity gain, smoother wide open;
    // the note-on is dropped since retrigger is off
    feed_tick(1'b0, '0);
    feed_tick(1'b1, SPOS_MAX);
    feed_tick(1'b0, SPOS_MIN);
    settle();

    // sync with a rate index past the table, gain above unity, level at the
    // floor, alpha above one: square swings into both saturation rails
    write_reg(CFG_SYNC_EN, 24'd1);
    write_reg(CFG_SYNC_RATE, 24'd15);
    write_reg(CFG_WAVE_SEL, 24'(WAVE_SQUARE));
    write_reg(CFG_AMPLITUDE, 24'h00_FFFF);
    write_reg(CFG_OFFSET, 24'h00_8000);
    write_reg(CFG_ALPHA, 24'h01_FFFF);
    feed_tick(1'b0, SPOS_MIN);
    feed_tick(1'b0, SPOS_MAX);
    feed_tick(1'b0, SPOS_NEG1);
    feed_tick(1'b0, 48'h0000_0080_0000);
    settle();

    // slowest sync rate, triangle at the top level
    write_reg(CFG_SYNC_RATE, 24'd0);
    write_reg(CFG_WAVE_SEL, 24'(WAVE_TRIANGLE));
    write_reg(CFG_OFFSET, 24'h00_7FFF);
    write_reg(CFG_ALPHA, 24'd65536);
    feed_tick(1'b0, '0);
    feed_tick(1'b0, 48'h0000_0800_0000);
    settle();

    // noise hold with retrigger, phase stepping backwards every tick,
    // smoother frozen so the output holds its level
    write_reg(CFG_SYNC_EN, 24'd0);
    write_reg(CFG_WAVE_SEL, 24'(WAVE_RANDOM));
    write_reg(CFG_RETRIG_EN, 24'd1);
    write_reg(CFG_PHASE_INC, 24'hFF_FFFF);
    write_reg(CFG_AMPLITUDE, 24'd32768);
    write_reg(CFG_OFFSET, 24'd0);
    write_reg(CFG_ALPHA, 24'd0);
    feed_tick(1'b1, '0);
    feed_tick(1'b0, '0);
    feed_tick(1'b0, '0);
    feed_tick(1'b1, SPOS_NEG1);
    settle();

    // saw at quarter-cycle steps through a half-open smoother
    write_reg(CFG_WAVE_SEL, 24'(WAVE_SAW));
    write_reg(CFG_ALPHA, 24'd32768);
    write_reg(CFG_PHASE_INC, 24'h40_0000);
    feed_tick(1'b0, '0);
    feed_tick(1'b1, '0);
    settle();

    // unused waveform codes give a zero wave
    for (int c = WAVE_RANDOM + 1; c < 8; c++) begin
      write_reg(CFG_WAVE_SEL, 24'(c));
      feed_tick(1'b0, '0);
      settle();
    end

    // random phases, each with its own register set
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      shuffle_regs();
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        feed_tick($urandom_range(0, 7) == 0, next_position());
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
